[hw/rtl/nnr_pkg.sv]
package nnr_pkg;

    localparam int DIM_W            = 13;
    localparam int DEPTH_W          = 3;
    localparam int CNT_W            = 12;
    localparam int EXC_W            = 14;
    localparam int CH_W             = 8;
    localparam int NUM_CH           = 4;
    localparam int SUM_W            = 10;
    localparam int CFG_ADDR_W       = 3;
    localparam int QUEUE_DEPTH      = 4;
    localparam int MAX_DIM_DEF      = 4096;
    localparam int MAX_CHANNELS_DEF = 4;

    // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for every x below 1024.
    localparam int RECIP3       = 2731;
    localparam int RECIP3_W     = 12;
    localparam int RECIP3_SHIFT = 13;

    localparam logic [DIM_W-1:0]   RST_SRC_WIDTH  = DIM_W'(64);
    localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT = DIM_W'(64);
    localparam logic [DEPTH_W-1:0] RST_SRC_DEPTH  = DEPTH_W'(3);
    localparam logic [DIM_W-1:0]   RST_DST_WIDTH  = DIM_W'(64);
    localparam logic [DIM_W-1:0]   RST_DST_HEIGHT = DIM_W'(64);
    localparam logic [DEPTH_W-1:0] RST_DST_DEPTH  = DEPTH_W'(3);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_SRC_DEPTH  = 3'd2,
        CFG_DST_WIDTH  = 3'd3,
        CFG_DST_HEIGHT = 3'd4,
        CFG_DST_DEPTH  = 3'd5
    } cfg_index_t;

    typedef enum logic [DEPTH_W-1:0] {
        DIV_BY_1 = 3'd1,
        DIV_BY_2 = 3'd2,
        DIV_BY_3 = 3'd3,
        DIV_BY_4 = 3'd4
    } div_code_t;

    typedef struct packed {
        logic [DIM_W-1:0]   src_width;
        logic [DIM_W-1:0]   src_height;
        logic [DEPTH_W-1:0] src_depth;
        logic [DIM_W-1:0]   dst_width;
        logic [DIM_W-1:0]   dst_height;
        logic [DEPTH_W-1:0] dst_depth;
    } cfg_t;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] chan;
        logic                        mono;
        logic [DEPTH_W-1:0]          div;
        logic                        last;
        logic                        err;
    } nnr_item_t;

endpackage

[hw/rtl/nearest_neighbour_image_resize.sv]
// Channel   Direction  Ports                          Contents
// s_        in         s_tvalid s_tready s_tuser      source pixel, frame start in tuser
//                      s_tdata
// m_        out        m_tvalid m_tready m_tdata      output pixel, frame end in tlast,
//                      m_tlast m_tuser                settings error in tuser
// cfg_      in         cfg_we cfg_addr cfg_wdata      register write, no read-back
//
// One source pixel is taken every cycle while the four-entry queue has room.
// A selected pixel passes through the queue memory and then the output register to m_tdata.
// The output register drains one beat a cycle while m_tready is high, so a stalled sink
// fills the queue and then holds s_tready low.
// Reset clears the counters and loads the default sizes; no clearing pass.
module nearest_neighbour_image_resize
    import nnr_pkg::*;
#(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [NUM_CH*CH_W-1:0]  s_tdata,   // chan0, chan1, chan2, chan3
    input  logic                    s_tuser,   // frame_start
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [NUM_CH*CH_W-1:0]  m_tdata,   // out0, out1, out2, out3
    output logic                    m_tlast,
    output logic                    m_tuser,   // config_error
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [DIM_W-1:0]        cfg_wdata
);

    cfg_t                        cfg_reg;
    cfg_t                        cfg_next;
    logic                        q_full;
    logic                        q_empty;
    logic                        pix_accept;
    logic                        push;
    logic                        pop;
    nnr_item_t                   front_item;
    nnr_item_t                   q_item;
    logic [NUM_CH-1:0][CH_W-1:0] out_chan;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SRC_WIDTH:  cfg_next.src_width  = cfg_wdata;
                CFG_SRC_HEIGHT: cfg_next.src_height = cfg_wdata;
                CFG_SRC_DEPTH:  cfg_next.src_depth  = cfg_wdata[DEPTH_W-1:0];
                CFG_DST_WIDTH:  cfg_next.dst_width  = cfg_wdata;
                CFG_DST_HEIGHT: cfg_next.dst_height = cfg_wdata;
                CFG_DST_DEPTH:  cfg_next.dst_depth  = cfg_wdata[DEPTH_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= RST_SRC_WIDTH;
            cfg_reg.src_height <= RST_SRC_HEIGHT;
            cfg_reg.src_depth  <= RST_SRC_DEPTH;
            cfg_reg.dst_width  <= RST_DST_WIDTH;
            cfg_reg.dst_height <= RST_DST_HEIGHT;
            cfg_reg.dst_depth  <= RST_DST_DEPTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready   = !q_full;
    assign pix_accept = s_tvalid && s_tready;

    nnr_front #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pix_accept  (pix_accept),
        .frame_start (s_tuser),
        .chan        (s_tdata),
        .push        (push),
        .item        (front_item)
    );

    nnr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_item (front_item),
        .full    (q_full),
        .rd_en   (pop),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    nnr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_chan  (out_chan),
        .out_last  (m_tlast),
        .out_err   (m_tuser)
    );

    assign m_tdata = out_chan;

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("error beat must be frame end with zero pixel data");

endmodule

[hw/rtl/nnr_fifo.sv]
module nnr_fifo
    import nnr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  nnr_item_t wr_item,
    output logic      full,
    input  logic      rd_en,
    output nnr_item_t rd_item,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

    nnr_item_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W_Q-1:0]  count_reg;
    logic [CNT_W_Q-1:0]  count_next;
    logic                push;
    logic                pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign push    = wr_en && !full;
    assign pop     = rd_en && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W_Q'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W_Q'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count exceeds its depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W_Q'(1)))
        else $error("queue count did not grow on a lone push");

endmodule

[hw/rtl/nnr_front.sv]
module nnr_front
    import nnr_pkg::*;
#(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        pix_accept,
    input  logic                        frame_start,
    input  logic [NUM_CH-1:0][CH_W-1:0] chan,
    output logic                        push,
    output nnr_item_t                   item
);

    logic [CNT_W-1:0] src_col_reg, src_col_next;
    logic [CNT_W-1:0] src_row_reg, src_row_next;
    logic [EXC_W-1:0] col_exc_reg, col_exc_next;
    logic [EXC_W-1:0] row_exc_reg, row_exc_next;
    logic [CNT_W-1:0] out_col_reg, out_col_next;
    logic [CNT_W-1:0] out_row_reg, out_row_next;

    logic [CNT_W-1:0] src_col, src_row, out_col, out_row;
    logic [EXC_W-1:0] col_exc, row_exc;
    logic             bad;
    logic             mono;
    logic             row_end;
    logic             frame_end;
    logic             row_sel;
    logic             col_sel;
    logic             last;
    logic [EXC_W-1:0] col_step;
    logic [EXC_W-1:0] row_step;
    logic [DEPTH_W-1:0] keep_depth;

    // A frame start restarts the frame before the pixel is classified.
    assign src_col = frame_start ? '0 : src_col_reg;
    assign src_row = frame_start ? '0 : src_row_reg;
    assign col_exc = frame_start ? '0 : col_exc_reg;
    assign row_exc = frame_start ? '0 : row_exc_reg;
    assign out_col = frame_start ? '0 : out_col_reg;
    assign out_row = frame_start ? '0 : out_row_reg;

    assign bad = (cfg.src_width == '0) || (int'(cfg.src_width) > MAX_DIM)
              || (cfg.src_height == '0) || (int'(cfg.src_height) > MAX_DIM)
              || (cfg.src_depth == '0) || (int'(cfg.src_depth) > MAX_CHANNELS)
              || (cfg.dst_width == '0) || (cfg.dst_width > cfg.src_width)
              || (cfg.dst_height == '0) || (cfg.dst_height > cfg.src_height)
              || ((cfg.dst_depth != DEPTH_W'(1)) && (cfg.dst_depth != cfg.src_depth));

    assign mono      = (cfg.dst_depth == DEPTH_W'(1));
    assign row_end   = ({1'b0, src_col} + DIM_W'(1)) >= cfg.src_width;
    assign frame_end = row_end && (({1'b0, src_row} + DIM_W'(1)) >= cfg.src_height);
    assign row_sel   = row_exc < {1'b0, cfg.dst_height};
    assign col_sel   = col_exc < {1'b0, cfg.dst_width};
    assign last      = (out_row == CNT_W'(cfg.dst_height - DIM_W'(1)))
                    && (out_col == CNT_W'(cfg.dst_width - DIM_W'(1)));

    assign col_step = col_sel ? ({1'b0, cfg.src_width} - {1'b0, cfg.dst_width})
                              : (EXC_W'(0) - {1'b0, cfg.dst_width});
    assign row_step = row_sel ? ({1'b0, cfg.src_height} - {1'b0, cfg.dst_height})
                              : (EXC_W'(0) - {1'b0, cfg.dst_height});

    assign push       = pix_accept && (bad ? frame_end : (row_sel && col_sel));
    assign keep_depth = mono ? cfg.src_depth : cfg.dst_depth;

    always_comb
    begin
        item      = '0;
        item.err  = bad;
        item.last = bad ? 1'b1 : last;
        item.mono = mono && !bad;
        item.div  = cfg.src_depth;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (!bad && (DEPTH_W'(i) < keep_depth))
            begin
                item.chan[i] = chan[i];
            end
        end
    end

    always_comb
    begin
        src_col_next = src_col + CNT_W'(1);
        src_row_next = src_row;
        col_exc_next = col_exc + col_step;
        row_exc_next = row_exc;
        out_col_next = col_sel ? out_col + CNT_W'(1) : out_col;
        out_row_next = out_row;
        if (row_end)
        begin
            src_col_next = '0;
            col_exc_next = '0;
            out_col_next = '0;
            out_row_next = row_sel ? out_row + CNT_W'(1) : out_row;
            row_exc_next = row_exc + row_step;
            src_row_next = src_row + CNT_W'(1);
            if (frame_end)
            begin
                src_row_next = '0;
                row_exc_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            col_exc_reg <= '0;
            row_exc_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (pix_accept)
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            col_exc_reg <= col_exc_next;
            row_exc_reg <= row_exc_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && row_end) |=> (src_col_reg == '0 && out_col_reg == '0))
        else $error("column state not cleared at the end of a row");

endmodule

[hw/rtl/nnr_back.sv]
module nnr_back
    import nnr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  nnr_item_t                   q_item,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [NUM_CH-1:0][CH_W-1:0] out_chan,
    output logic                        out_last,
    output logic                        out_err
);

    logic                        valid_reg;
    logic [NUM_CH-1:0][CH_W-1:0] chan_reg, chan_next;
    logic                        last_reg;
    logic                        err_reg;
    logic [SUM_W-1:0]            sum;
    logic [SUM_W+RECIP3_W-1:0]   prod;
    logic [CH_W-1:0]             avg;

    assign pop = !q_empty && (!valid_reg || out_ready);

    assign sum = SUM_W'(q_item.chan[0]) + SUM_W'(q_item.chan[1])
               + SUM_W'(q_item.chan[2]) + SUM_W'(q_item.chan[3]);
    assign prod = (SUM_W+RECIP3_W)'(sum) * (SUM_W+RECIP3_W)'(RECIP3);

    always_comb
    begin
        case (q_item.div)
            DIV_BY_1: avg = CH_W'(sum);
            DIV_BY_2: avg = CH_W'(sum >> 1);
            DIV_BY_3: avg = prod[RECIP3_SHIFT +: CH_W];
            DIV_BY_4: avg = CH_W'(sum >> 2);
            default:  avg = CH_W'(sum);
        endcase
    end

    always_comb
    begin
        chan_next = q_item.chan;
        if (q_item.mono)
        begin
            chan_next    = '0;
            chan_next[0] = avg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            chan_reg <= chan_next;
            last_reg <= q_item.last;
            err_reg  <= q_item.err;
        end
    end

    assign out_valid = valid_reg;
    assign out_chan  = chan_reg;
    assign out_last  = last_reg;
    assign out_err   = err_reg;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import nnr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TOTAL_PIXELS = 900;
    localparam int WIDE_ROW_PIXELS = 48;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] chan;
        logic                        last;
        logic                        err;
    } pixel_t;

    class resize_scoreboard;
        int unsigned src_width = 64, src_height = 64, src_depth = 3;
        int unsigned dst_width = 64, dst_height = 64, dst_depth = 3;
        int unsigned src_col, src_row, col_excess, row_excess, out_col, out_row;
        pixel_t      expected_px[$];
        int          mismatches;

        function void clear_position();
            src_col = 0;
            src_row = 0;
            col_excess = 0;
            row_excess = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [DIM_W-1:0] val);
            case (addr)
                CFG_SRC_WIDTH:  src_width = 32'(val);
                CFG_SRC_HEIGHT: src_height = 32'(val);
                CFG_SRC_DEPTH:  src_depth = 32'(val[DEPTH_W-1:0]);
                CFG_DST_WIDTH:  dst_width = 32'(val);
                CFG_DST_HEIGHT: dst_height = 32'(val);
                CFG_DST_DEPTH:  dst_depth = 32'(val[DEPTH_W-1:0]);
                default: ;
            endcase
        endfunction

        function bit settings_invalid();
            if (src_width == 0 || src_width > MAX_DIM_DEF) return 1;
            if (src_height == 0 || src_height > MAX_DIM_DEF) return 1;
            if (src_depth == 0 || src_depth > MAX_CHANNELS_DEF) return 1;
            if (dst_width == 0 || dst_width > src_width) return 1;
            if (dst_height == 0 || dst_height > src_height) return 1;
            return dst_depth != 1 && dst_depth != src_depth;
        endfunction

        function void note_pixel(bit frame_start, logic [NUM_CH*CH_W-1:0] data);
            pixel_t      px;
            bit          invalid, row_end, frame_end, row_hit, col_hit;
            int unsigned sum;

            if (frame_start)
                clear_position();
            invalid = settings_invalid();
            row_end = (src_col + 1) >= src_width;
            frame_end = row_end && ((src_row + 1) >= src_height);
            row_hit = row_excess < dst_height;
            col_hit = col_excess < dst_width;
            px = '0;
            if (invalid)
            begin
                if (frame_end)
                begin
                    px.last = 1'b1;
                    px.err = 1'b1;
                    expected_px.push_back(px);
                end
            end
            else if (row_hit && col_hit)
            begin
                if (dst_depth == 1)
                begin
                    sum = 0;
                    for (int i = 0; i < NUM_CH; i++)
                        if (i < src_depth)
                            sum += 32'(data[i*CH_W +: CH_W]);
                    px.chan[0] = CH_W'(sum / src_depth);
                end
                else
                begin
                    for (int i = 0; i < NUM_CH; i++)
                        px.chan[i] = (i < dst_depth) ? data[i*CH_W +: CH_W] : '0;
                end
                px.last = out_row == dst_height - 1 && out_col == dst_width - 1;
                expected_px.push_back(px);
            end

            if (col_hit)
            begin
                out_col = (out_col + 1) & 'hFFF;
                col_excess = (col_excess + src_width) & 'h3FFF;
            end
            col_excess = (col_excess - dst_width) & 'h3FFF;
            if (row_end)
            begin
                src_col = 0;
                col_excess = 0;
                out_col = 0;
                if (row_hit)
                begin
                    out_row = (out_row + 1) & 'hFFF;
                    row_excess = (row_excess + src_height) & 'h3FFF;
                end
                row_excess = (row_excess - dst_height) & 'h3FFF;
                src_row = (src_row + 1) & 'hFFF;
                if (frame_end)
                    clear_position();
            end
            else
            begin
                src_col = (src_col + 1) & 'hFFF;
            end
        endfunction

        function void check_pixel(logic [NUM_CH*CH_W-1:0] data, logic last, logic err);
            pixel_t exp_px;

            if (expected_px.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got data %h last %b err %b",
                         $time, data, last, err);
                mismatches++;
                return;
            end
            exp_px = expected_px.pop_front();
            for (int i = 0; i < NUM_CH; i++)
                if (data[i*CH_W +: CH_W] !== exp_px.chan[i])
                begin
                    $display("%0t: out%0d expected %h, got %h",
                             $time, i, exp_px.chan[i], data[i*CH_W +: CH_W]);
                    mismatches++;
                end
            if (last !== exp_px.last)
            begin
                $display("%0t: frame_last expected %b, got %b", $time, exp_px.last, last);
                mismatches++;
            end
            if (err !== exp_px.err)
            begin
                $display("%0t: config_error expected %b, got %b", $time, exp_px.err, err);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_px.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [NUM_CH*CH_W-1:0]   s_tdata = '0;
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [NUM_CH*CH_W-1:0]   m_tdata;
    logic                     m_tlast;
    logic                     m_tuser;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
    logic [DIM_W-1:0]         cfg_wdata = '0;

    resize_scoreboard sb = new();
    int               burst_left;
    int               pixels_sent;
    int               cycle_count;
    int               sink_cycle;

    nearest_neighbour_image_resize i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The sink cycles through four stall patterns: none, random, sparse and long runs.
    always @(posedge clk)
    begin
        sink_cycle++;
        case ((sink_cycle / 200) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (sink_cycle % 4) == 0;
            default: m_tready <= (sink_cycle % 32) >= 12;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tlast, m_tuser);
    end

    task automatic send_pixel(bit frame_start, logic [NUM_CH*CH_W-1:0] data);
        int gap;

        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= frame_start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pixel(frame_start, data);
        burst_left--;
        pixels_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [DIM_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(addr, val);
    endtask

    task automatic set_config(cfg_t c);
        logic [DIM_W-DEPTH_W-1:0] noise;

        noise = ($urandom_range(0, 3) == 0) ? (DIM_W-DEPTH_W)'($urandom()) : '0;
        write_reg(CFG_SRC_WIDTH, c.src_width);
        write_reg(CFG_SRC_HEIGHT, c.src_height);
        write_reg(CFG_SRC_DEPTH, {noise, c.src_depth});
        write_reg(CFG_DST_WIDTH, c.dst_width);
        write_reg(CFG_DST_HEIGHT, c.dst_height);
        write_reg(CFG_DST_DEPTH, {noise, c.dst_depth});
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        int   pick;

        c.src_width = DIM_W'($urandom_range(1, 8));
        c.src_height = DIM_W'($urandom_range(1, 8));
        c.src_depth = DEPTH_W'($urandom_range(1, 4));
        pick = $urandom_range(0, 19);
        if (pick >= 14 && pick < 16)
        begin
            c.src_width = $urandom_range(0, 1) ? DIM_W'(MAX_DIM_DEF)
                                               : DIM_W'($urandom_range(9, MAX_DIM_DEF));
            c.src_height = $urandom_range(0, 1) ? DIM_W'(MAX_DIM_DEF)
                                                : DIM_W'($urandom_range(9, MAX_DIM_DEF));
        end
        c.dst_width = DIM_W'($urandom_range(1, c.src_width));
        c.dst_height = DIM_W'($urandom_range(1, c.src_height));
        c.dst_depth = $urandom_range(0, 1) ? DEPTH_W'(1) : c.src_depth;
        if (pick >= 16)
        begin
            case ($urandom_range(0, 7))
                0: c.src_width = '0;
                1: c.src_height = DIM_W'($urandom_range(MAX_DIM_DEF + 1, 8191));
                2: c.src_depth = $urandom_range(0, 1) ? DEPTH_W'(0)
                                                      : DEPTH_W'($urandom_range(5, 7));
                3: c.dst_width = DIM_W'($urandom_range(c.src_width + 1, 8191));
                4: c.dst_height = '0;
                5: c.src_width = DIM_W'(8191);
                6: c.dst_width = '0;
                default:
                begin
                    do
                        c.dst_depth = DEPTH_W'($urandom_range(0, 7));
                    while (c.dst_depth == 1 || c.dst_depth == c.src_depth);
                end
            endcase
        end
        return c;
    endfunction

    function automatic logic [NUM_CH*CH_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            default: return $urandom();
        endcase
    endfunction

    // Mostly whole frames; the rest are cut short or carry stray frame starts.
    task automatic run_frames(cfg_t c, int frames);
        int unsigned area;
        int          len;
        bit          whole;

        area = int'(c.src_width) * int'(c.src_height);
        for (int f = 0; f < frames; f++)
        begin
            whole = area != 0 && area <= 64 && $urandom_range(0, 9) < 8;
            len = whole ? int'(area) : $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
            begin
                if (whole)
                    send_pixel(k == 0 && $urandom_range(0, 3) != 0, random_sample());
                else
                    send_pixel($urandom_range(0, 7) == 0, random_sample());
            end
        end
    endtask

    initial
    begin
        cfg_t c;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default sizes: every pixel is copied.
        send_pixel(1'b1, '1);
        send_pixel(1'b0, '0);
        send_pixel(1'b0, 32'h00FF00FF);
        send_pixel(1'b0, 32'hFF00FF00);
        wait_idle();

        // Four channels averaged, 2x2 down to 1x1.
        c = '{src_width: 2, src_height: 2, src_depth: 4,
              dst_width: 1, dst_height: 1, dst_depth: 1};
        set_config(c);
        repeat (4) send_pixel(1'b0, '1);
        wait_idle();

        // Three channels averaged; the fourth is ignored.
        c = '{src_width: 1, src_height: 1, src_depth: 3,
              dst_width: 1, dst_height: 1, dst_depth: 1};
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, '1);
        set_config(c);
        send_pixel(1'b1, 32'h12FFFFFF);
        send_pixel(1'b0, 32'hFF010203);
        wait_idle();

        // Output depth neither one nor the source depth.
        c = '{src_width: 2, src_height: 1, src_depth: 3,
              dst_width: 2, dst_height: 1, dst_depth: 2};
        set_config(c);
        send_pixel(1'b1, '1);
        send_pixel(1'b0, '1);
        wait_idle();

        // The start of a row at the largest width.
        c = '{src_width: MAX_DIM_DEF, src_height: 1, src_depth: 4,
              dst_width: MAX_DIM_DEF - 1, dst_height: 1, dst_depth: 4};
        set_config(c);
        for (int k = 0; k < WIDE_ROW_PIXELS; k++)
            send_pixel(k == 0, random_sample());
        wait_idle();

        while (pixels_sent < TOTAL_PIXELS)
        begin
            c = random_settings();
            set_config(c);
            run_frames(c, $urandom_range(1, 5));
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
